// ===== rtl/core/mdkw_pkg.sv =====
package mdkw_pkg;

    localparam int POS_W = 16;
    localparam int LEN_W = 16;
    localparam int KEY_W = 4;
    localparam int END_W = 17;
    localparam int BCNT_W = 5;
    localparam int SLEN_W = 16;

    localparam logic [SLEN_W-1:0] SUMMARY_LEN_RESET = 16'd256;
    localparam logic [END_W-1:0] END_LIMIT = 17'h10000;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PUSH  = 3'b010,
        S_CHECK = 3'b100
    } t_state;

endpackage

// ===== rtl/core/mdkw_hit_if.sv =====
interface mdkw_hit_if;
    logic                          valid;
    logic                          ready;
    logic                          first_hit;
    logic [mdkw_pkg::POS_W-1:0]    hit_pos;
    logic [mdkw_pkg::LEN_W-1:0]    hit_len;
    logic [mdkw_pkg::KEY_W-1:0]    keyword_index;

    modport source (output valid, output first_hit, output hit_pos, output hit_len,
                    output keyword_index, input ready);
    modport sink   (input valid, input first_hit, input hit_pos, input hit_len,
                    input keyword_index, output ready);
endinterface

// ===== rtl/core/mdkw_res_if.sv =====
interface mdkw_res_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [mdkw_pkg::POS_W-1:0]    best_begin;
    logic [mdkw_pkg::END_W-1:0]    best_end;
    logic [mdkw_pkg::BCNT_W-1:0]   best_count;
    logic                          overflow;

    modport source (output valid, output found, output best_begin, output best_end,
                    output best_count, output overflow, input ready);
    modport sink   (input valid, input found, input best_begin, input best_end,
                    input best_count, input overflow, output ready);
endinterface

// ===== rtl/core/mdkw_cfg_if.sv =====
interface mdkw_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mdkw_pkg::SLEN_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/max_distinct_key_window.sv =====
// An accepted hit is stored in S_PUSH; in S_CHECK the oldest hits are popped while
// the hit's end lies past their begin plus summary_len, and the result is valid once no
// pop is due or the pops empty the window. A hit with an out-of-range keyword index, or
// dropped on a full store, gets its result from S_PUSH. More pops are due for a later end.
// The next hit is accepted at the earliest on the edge that accepts the result.
// Reset (synchronous, active low): clears counts, indices, best window and sets
// summary_len to 256; the window store is not cleared.
module max_distinct_key_window #(
    parameter int KEYWORDS    = 16,
    parameter int WINDOW_HITS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mdkw_hit_if.sink          i_hit,
    mdkw_res_if.source        o_res,
    mdkw_cfg_if.sink          i_cfg
);

    localparam int AW  = (WINDOW_HITS > 1) ? $clog2(WINDOW_HITS) : 1;
    localparam int FW  = $clog2(WINDOW_HITS + 1);
    localparam int CW  = $clog2(WINDOW_HITS + 1);
    localparam int KIW = (KEYWORDS > 1) ? $clog2(KEYWORDS) : 1;
    localparam int DW  = $clog2(KEYWORDS + 1);
    localparam int EW  = mdkw_pkg::POS_W + KIW;

    mdkw_pkg::t_state r_state;

    logic [mdkw_pkg::SLEN_W-1:0] r_sum_len;
    logic [mdkw_pkg::POS_W-1:0]  r_pos;
    logic [mdkw_pkg::LEN_W-1:0]  r_len;
    logic [mdkw_pkg::KEY_W-1:0]  r_key;
    logic [mdkw_pkg::END_W-1:0]  r_end;
    logic                        r_bypass;

    logic [AW-1:0]               r_head;
    logic [AW-1:0]               r_tail;
    logic [FW-1:0]               r_fill;
    logic [CW-1:0]               r_cnt [KEYWORDS];
    logic [DW-1:0]               r_dist_now;
    logic [DW-1:0]               r_dist_best;
    logic [mdkw_pkg::POS_W-1:0]  r_begin_best;
    logic [mdkw_pkg::END_W-1:0]  r_end_best;
    logic                        r_out_valid;
    logic                        r_overflow;

    logic [EW-1:0]               r_mem [WINDOW_HITS];
    logic [EW-1:0]               r_rd;

    logic                        hit_acc;
    logic                        key_ok;
    logic                        full;
    logic [KIW-1:0]              push_k;
    logic [KIW-1:0]              pop_k;
    logic [mdkw_pkg::POS_W-1:0]  cur_begin;
    logic                        do_pop;
    logic [AW-1:0]               n_head;
    logic [FW-1:0]               n_fill;
    logic [AW-1:0]               rd_addr;
    logic                        mem_we;
    logic [mdkw_pkg::END_W-1:0]  end_sum;
    logic [mdkw_pkg::END_W-1:0]  lim_sum;
    logic [CW-1:0]               pop_cnt;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        next_slot = (idx == AW'(WINDOW_HITS - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign hit_acc     = i_hit.valid && i_hit.ready;
    assign i_hit.ready = (r_state == mdkw_pkg::S_IDLE) && (!r_out_valid || o_res.ready);
    assign i_cfg.ready = 1'b1;

    assign key_ok = (32'(r_key) < KEYWORDS);
    assign full   = (r_fill == FW'(WINDOW_HITS));
    assign push_k = KIW'(r_key);
    assign pop_k  = r_bypass ? push_k : r_rd[KIW-1:0];

    assign cur_begin = r_bypass ? r_pos : r_rd[EW-1:KIW];
    assign lim_sum   = {1'b0, cur_begin} + {1'b0, r_sum_len};
    assign do_pop    = (r_state == mdkw_pkg::S_CHECK) && (r_end > lim_sum);
    assign n_head    = next_slot(r_head);
    assign n_fill    = r_fill - 1'b1;
    assign pop_cnt   = r_cnt[pop_k];

    assign end_sum = {1'b0, r_pos} + {1'b0, r_len};
    assign mem_we  = (r_state == mdkw_pkg::S_PUSH) && key_ok && !full;
    assign rd_addr = do_pop ? n_head : r_head;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= {r_pos, push_k};
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (hit_acc) begin
            r_pos   <= i_hit.hit_pos;
            r_len   <= i_hit.hit_len;
            r_key   <= i_hit.keyword_index;
        end
        if (r_state == mdkw_pkg::S_PUSH) begin
            r_end    <= (end_sum > mdkw_pkg::END_LIMIT) ? mdkw_pkg::END_LIMIT : end_sum;
            r_bypass <= (r_fill == '0);
        end else if (do_pop) begin
            r_bypass <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mdkw_pkg::S_IDLE;
            r_sum_len    <= mdkw_pkg::SUMMARY_LEN_RESET;
            r_head       <= '0;
            r_tail       <= '0;
            r_fill       <= '0;
            r_dist_now   <= '0;
            r_dist_best  <= '0;
            r_begin_best <= '0;
            r_end_best   <= '0;
            r_out_valid  <= 1'b0;
            r_overflow   <= 1'b0;
            for (int i = 0; i < KEYWORDS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_sum_len <= i_cfg.data;
            end
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                mdkw_pkg::S_IDLE: begin
                    if (hit_acc) begin
                        if (i_hit.first_hit) begin
                            r_head       <= '0;
                            r_tail       <= '0;
                            r_fill       <= '0;
                            r_dist_now   <= '0;
                            r_dist_best  <= '0;
                            r_begin_best <= '0;
                            r_end_best   <= '0;
                            for (int i = 0; i < KEYWORDS; i++) begin
                                r_cnt[i] <= '0;
                            end
                        end
                        r_state <= mdkw_pkg::S_PUSH;
                    end
                end
                mdkw_pkg::S_PUSH: begin
                    if (!key_ok || full) begin
                        r_overflow  <= key_ok && full;
                        r_out_valid <= 1'b1;
                        r_state     <= mdkw_pkg::S_IDLE;
                    end else begin
                        r_tail        <= next_slot(r_tail);
                        r_fill        <= r_fill + 1'b1;
                        r_cnt[push_k] <= r_cnt[push_k] + 1'b1;
                        if (r_cnt[push_k] == '0) begin
                            r_dist_now <= r_dist_now + 1'b1;
                        end
                        r_state <= mdkw_pkg::S_CHECK;
                    end
                end
                mdkw_pkg::S_CHECK: begin
                    if (do_pop) begin
                        if (pop_cnt != '0) begin
                            r_cnt[pop_k] <= pop_cnt - 1'b1;
                            if (pop_cnt == CW'(1) && r_dist_now != '0) begin
                                r_dist_now <= r_dist_now - 1'b1;
                            end
                        end
                        r_head <= n_head;
                        r_fill <= n_fill;
                        if (n_fill == '0) begin
                            r_overflow  <= 1'b0;
                            r_out_valid <= 1'b1;
                            r_state     <= mdkw_pkg::S_IDLE;
                        end
                    end else begin
                        if (r_dist_now > r_dist_best) begin
                            r_dist_best  <= r_dist_now;
                            r_begin_best <= cur_begin;
                            r_end_best   <= r_end;
                        end
                        r_overflow  <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= mdkw_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= mdkw_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.found      = (r_dist_best != '0);
    assign o_res.best_begin = r_begin_best;
    assign o_res.best_end   = r_end_best;
    assign o_res.best_count = mdkw_pkg::BCNT_W'(r_dist_best);
    assign o_res.overflow   = r_overflow;

endmodule
